>>> hdl/yhpds_pkg.sv
// Package for the yaw-hold PID differential steer unit.
// Register indexes, reset gains, widths and limits; no dependencies.
package yhpds_pkg;

   localparam int SPEED_W   = 12;
   localparam int SPEED_MAX = 4095;
   localparam int DIFF_W    = 25;
   localparam int SUM_W     = 26;

   typedef logic [SPEED_W-1:0] speed_type;
   typedef logic [2:0]         reg_index_type;

   localparam reg_index_type REG_GAIN_P_FWD  = 3'd0;
   localparam reg_index_type REG_GAIN_I_FWD  = 3'd1;
   localparam reg_index_type REG_GAIN_D_FWD  = 3'd2;
   localparam reg_index_type REG_GAIN_P_BACK = 3'd3;
   localparam reg_index_type REG_GAIN_I_BACK = 3'd4;
   localparam reg_index_type REG_GAIN_D_BACK = 3'd5;

   localparam logic [31:0] GAIN_P_FWD_RST  = 32'd65536;
   localparam logic [31:0] GAIN_I_FWD_RST  = 32'd0;
   localparam logic [31:0] GAIN_D_FWD_RST  = 32'd655360;
   localparam logic [31:0] GAIN_P_BACK_RST = 32'd65536;
   localparam logic [31:0] GAIN_I_BACK_RST = 32'd66;
   localparam logic [31:0] GAIN_D_BACK_RST = 32'd655360;

   // integral product clamp, +-2^61
   localparam logic signed [64:0] ITERM_LIMIT = 65'sh2000_0000_0000_0000;
   // speed difference cap, 2^24
   localparam logic [41:0] DIFF_CAP = 42'h100_0000;
   localparam logic [SUM_W-1:0] SPEED_LIMIT = SUM_W'(SPEED_MAX);

endpackage

>>> hdl/yhpds_if.sv
// Request and response channel interfaces of the yaw-hold steer unit.
// Depends on yhpds_pkg for the speed type.
interface yhpds_req_if;
   logic               valid;
   logic               ready;
   logic               action;
   logic               direction;
   logic signed [15:0] yaw;
   logic [11:0]        base_speed;

   modport source (output valid, action, direction, yaw, base_speed, input ready);
   modport sink   (input valid, action, direction, yaw, base_speed, output ready);
endinterface

interface yhpds_rsp_if;
   logic                  valid;
   logic                  ready;
   yhpds_pkg::speed_type  left_cmd;
   yhpds_pkg::speed_type  right_cmd;
   logic                  saturated;

   modport source (output valid, left_cmd, right_cmd, saturated, input ready);
   modport sink   (input valid, left_cmd, right_cmd, saturated, output ready);
endinterface

>>> hdl/yaw_hold_pid_differential_steer_unit.sv
// Yaw-hold PID with differential wheel steering, per-direction PID state and gains.
// Throughput: one request per cycle; the pipeline (input reg, error/state, multiply,
// accumulate, speed) only stops while the response register is held by the sink.
// Reset (synchronous): gains to their defaults, heading and PID state to zero,
// pipeline empty. Depends on yhpds_pkg and yhpds_if.
module yaw_hold_pid_differential_steer_unit (
   input  logic                clock,
   input  logic                reset,
   yhpds_req_if.sink           req_chan,
   yhpds_rsp_if.source         rsp_chan,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [4:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);
   import yhpds_pkg::*;

   // configuration
   logic [31:0] gain_p_fwd_ff, gain_i_fwd_ff, gain_d_fwd_ff;
   logic [31:0] gain_p_back_ff, gain_i_back_ff, gain_d_back_ff;
   reg_index_type csr_index;
   logic csr_write;

   assign pready    = 1'b1;
   assign csr_index = paddr[4:2];
   assign csr_write = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_fwd_ff  <= GAIN_P_FWD_RST;
         gain_i_fwd_ff  <= GAIN_I_FWD_RST;
         gain_d_fwd_ff  <= GAIN_D_FWD_RST;
         gain_p_back_ff <= GAIN_P_BACK_RST;
         gain_i_back_ff <= GAIN_I_BACK_RST;
         gain_d_back_ff <= GAIN_D_BACK_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_GAIN_P_FWD:  gain_p_fwd_ff  <= pwdata;
            REG_GAIN_I_FWD:  gain_i_fwd_ff  <= pwdata;
            REG_GAIN_D_FWD:  gain_d_fwd_ff  <= pwdata;
            REG_GAIN_P_BACK: gain_p_back_ff <= pwdata;
            REG_GAIN_I_BACK: gain_i_back_ff <= pwdata;
            REG_GAIN_D_BACK: gain_d_back_ff <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_GAIN_P_FWD:  prdata = gain_p_fwd_ff;
         REG_GAIN_I_FWD:  prdata = gain_i_fwd_ff;
         REG_GAIN_D_FWD:  prdata = gain_d_fwd_ff;
         REG_GAIN_P_BACK: prdata = gain_p_back_ff;
         REG_GAIN_I_BACK: prdata = gain_i_back_ff;
         REG_GAIN_D_BACK: prdata = gain_d_back_ff;
         default:         prdata = '0;
      endcase
   end

   // pipeline moves whenever the response register is free or being taken
   logic advance;
   assign advance        = !rsp_chan.valid || rsp_chan.ready;
   assign req_chan.ready = advance;

   // stage 0: input register
   logic               s0_valid_ff;
   logic               s0_action_ff, s0_dir_ff;
   logic signed [15:0] s0_yaw_ff;
   logic [11:0]        s0_base_ff;

   // controller state
   logic signed [15:0] target_ff;
   logic signed [31:0] error_sum_ff [2];
   logic signed [16:0] last_error_ff [2];

   // stage 1: error, integral, derivative
   logic signed [15:0] tgt_in;
   logic signed [31:0] es_old;
   logic signed [16:0] le_old;
   logic signed [16:0] err_in;
   logic signed [32:0] sum_wide;
   logic signed [31:0] sum_in;
   logic               sum_sat;
   logic signed [17:0] deriv_in;

   always_comb begin
      tgt_in   = s0_action_ff ? s0_yaw_ff : target_ff;
      es_old   = s0_action_ff ? 32'sd0 : error_sum_ff[s0_dir_ff];
      le_old   = s0_action_ff ? 17'sd0 : last_error_ff[s0_dir_ff];
      err_in   = 17'(tgt_in) - 17'(s0_yaw_ff);
      sum_wide = 33'(es_old) + 33'(err_in);
      sum_sat  = sum_wide[32] != sum_wide[31];
      if (!sum_sat)
         sum_in = sum_wide[31:0];
      else if (sum_wide[32])
         sum_in = 32'sh8000_0000;
      else
         sum_in = 32'sh7fff_ffff;
      deriv_in = 18'(err_in) - 18'(le_old);
   end

   logic               s1_valid_ff, s1_dir_ff, s1_sat_ff;
   logic signed [16:0] s1_err_ff;
   logic signed [31:0] s1_sum_ff;
   logic signed [17:0] s1_deriv_ff;
   logic [11:0]        s1_base_ff;

   // stage 2: gain products
   logic [31:0]        kp, ki, kd;
   logic signed [49:0] prod_p_in;
   logic signed [64:0] prod_i_in;
   logic signed [50:0] prod_d_in;

   always_comb begin
      kp = s1_dir_ff ? gain_p_back_ff : gain_p_fwd_ff;
      ki = s1_dir_ff ? gain_i_back_ff : gain_i_fwd_ff;
      kd = s1_dir_ff ? gain_d_back_ff : gain_d_fwd_ff;
      prod_p_in = $signed({1'b0, kp}) * s1_err_ff;
      prod_i_in = $signed({1'b0, ki}) * s1_sum_ff;
      prod_d_in = $signed({1'b0, kd}) * s1_deriv_ff;
   end

   logic               s2_valid_ff, s2_sat_ff, s2_nz_ff, s2_raise_ff;
   logic signed [49:0] s2_prod_p_ff;
   logic signed [64:0] s2_prod_i_ff;
   logic signed [50:0] s2_prod_d_ff;
   logic [11:0]        s2_base_ff;

   // stage 3: accumulate, magnitude, scale
   logic signed [64:0] iterm;
   logic signed [63:0] acc;
   logic [63:0]        mag;
   logic [41:0]        diff_full;
   logic [DIFF_W-1:0]  diff_in;

   always_comb begin
      if (s2_prod_i_ff > ITERM_LIMIT)
         iterm = ITERM_LIMIT;
      else if (s2_prod_i_ff < -ITERM_LIMIT)
         iterm = -ITERM_LIMIT;
      else
         iterm = s2_prod_i_ff;
      acc       = 64'(s2_prod_p_ff) + 64'(s2_prod_d_ff) + iterm[63:0];
      mag       = acc[63] ? 64'(-acc) : 64'(acc);
      diff_full = mag[63:22];
      diff_in   = (diff_full > DIFF_CAP) ? DIFF_W'(DIFF_CAP) : diff_full[DIFF_W-1:0];
   end

   logic              s3_valid_ff, s3_sat_ff, s3_nz_ff, s3_raise_ff;
   logic [DIFF_W-1:0] s3_diff_ff;
   logic [11:0]       s3_base_ff;

   // stage 4: wheel speeds and clipping
   logic [SUM_W-1:0] raised, left_w, right_w;
   logic             left_clip, right_clip;
   speed_type        left_in, right_in;

   always_comb begin
      raised     = SUM_W'(s3_base_ff) + SUM_W'(s3_diff_ff);
      left_w     = (s3_nz_ff && !s3_raise_ff) ? raised : SUM_W'(s3_base_ff);
      right_w    = (s3_nz_ff &&  s3_raise_ff) ? raised : SUM_W'(s3_base_ff);
      left_clip  = left_w > SPEED_LIMIT;
      right_clip = right_w > SPEED_LIMIT;
      left_in    = left_clip  ? SPEED_LIMIT[SPEED_W-1:0] : left_w[SPEED_W-1:0];
      right_in   = right_clip ? SPEED_LIMIT[SPEED_W-1:0] : right_w[SPEED_W-1:0];
   end

   logic      rsp_valid_ff, rsp_sat_ff;
   speed_type rsp_left_ff, rsp_right_ff;

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff      <= 1'b0;
         s1_valid_ff      <= 1'b0;
         s2_valid_ff      <= 1'b0;
         s3_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         target_ff        <= '0;
         error_sum_ff[0]  <= '0;
         error_sum_ff[1]  <= '0;
         last_error_ff[0] <= '0;
         last_error_ff[1] <= '0;
      end else if (advance) begin
         s0_valid_ff  <= req_chan.valid;
         s1_valid_ff  <= s0_valid_ff;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         rsp_valid_ff <= s3_valid_ff;
         if (s0_valid_ff) begin
            target_ff                <= tgt_in;
            error_sum_ff[s0_dir_ff]  <= sum_in;
            last_error_ff[s0_dir_ff] <= err_in;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (advance) begin
         s0_action_ff <= req_chan.action;
         s0_dir_ff    <= req_chan.direction;
         s0_yaw_ff    <= req_chan.yaw;
         s0_base_ff   <= req_chan.base_speed;

         s1_dir_ff   <= s0_dir_ff;
         s1_sat_ff   <= sum_sat;
         s1_err_ff   <= err_in;
         s1_sum_ff   <= sum_in;
         s1_deriv_ff <= deriv_in;
         s1_base_ff  <= s0_base_ff;

         s2_sat_ff    <= s1_sat_ff;
         s2_nz_ff     <= s1_err_ff != 17'sd0;
         // right wheel gets the boost when error sign matches direction code
         s2_raise_ff  <= s1_err_ff[16] == s1_dir_ff;
         s2_prod_p_ff <= prod_p_in;
         s2_prod_i_ff <= prod_i_in;
         s2_prod_d_ff <= prod_d_in;
         s2_base_ff   <= s1_base_ff;

         s3_sat_ff   <= s2_sat_ff;
         s3_nz_ff    <= s2_nz_ff;
         s3_raise_ff <= s2_raise_ff;
         s3_diff_ff  <= diff_in;
         s3_base_ff  <= s2_base_ff;

         rsp_left_ff  <= left_in;
         rsp_right_ff <= right_in;
         rsp_sat_ff   <= s3_sat_ff | left_clip | right_clip;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.left_cmd  = rsp_left_ff;
   assign rsp_chan.right_cmd = rsp_right_ff;
   assign rsp_chan.saturated = rsp_sat_ff;

endmodule
